@@ rtl/core/rlfe_pkg.sv @@
// ----------------------------------------------------------------------------
// rlfe_pkg
// shared types and constants of the rectangle and line fill engine
// ----------------------------------------------------------------------------
package rlfe_pkg;

    localparam int unsigned FrameWidth  = 64;
    localparam int unsigned FrameHeight = 64;
    localparam logic [31:0] BlendMaskReset = 32'hFEFE_FEFE;

    typedef enum logic [2:0] {
        MODE_PIXEL   = 3'd0,
        MODE_HLINE   = 3'd1,
        MODE_VLINE   = 3'd2,
        MODE_OUTLINE = 3'd3,
        MODE_SHADE   = 3'd4,
        MODE_MESH    = 3'd5,
        MODE_FILL    = 3'd6,
        MODE_READ    = 3'd7
    } t_mode;

    localparam logic [0:0] REG_SHADE = 1'b0;
    localparam logic [0:0] REG_MASK  = 1'b1;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [7:0]  x;
        logic signed [7:0]  y;
        logic signed [7:0]  x_end;
        logic signed [7:0]  y_end;
        logic signed [7:0]  length;
        logic [31:0]        color;
    } t_cmd_in;

    typedef struct packed {
        logic [31:0] pixel_value;
        logic        clipped;
    } t_result;

    // one walk over a rectangle of pixels, queued between front and back
    typedef struct packed {
        logic               shade;
        logic               rd;
        logic               mesh;
        logic               last;
        logic signed [9:0]  x0;
        logic signed [9:0]  y0;
        logic [8:0]         nx;
        logic [8:0]         ny;
        logic [31:0]        color;
    } t_span;

endpackage

@@ rtl/core/rlfe_front.sv @@
// ----------------------------------------------------------------------------
// rlfe_front
// accepts commands and splits them into rectangle spans
// ----------------------------------------------------------------------------
module rlfe_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_full,
    input  rlfe_pkg::t_cmd_in i_cmd,
    output logic             o_span_valid,
    output rlfe_pkg::t_span  o_span,
    input  logic             i_span_ready
);

    rlfe_pkg::t_cmd_in r_cmd, n_cmd;
    logic              r_busy, n_busy;
    logic [1:0]        r_part, n_part;

    logic signed [9:0] x, y, x2, y2, len, dx, dy, adx, ady;
    logic signed [9:0] hx, vy;
    logic [8:0]        hl, vl;
    rlfe_pkg::t_span   s;

    always_comb begin
        x   = 10'(r_cmd.x);
        y   = 10'(r_cmd.y);
        x2  = 10'(r_cmd.x_end);
        y2  = 10'(r_cmd.y_end);
        len = 10'(r_cmd.length);
        dx  = x2 - x;
        dy  = y2 - y;
        adx = dx[9] ? -dx : dx;
        ady = dy[9] ? -dy : dy;
        hx  = dx[9] ? x + dx : x;
        hl  = adx[8:0];
        vy  = dy[9] ? y + dy : y;
        vl  = ady[8:0];
        s = '0;
        s.color = r_cmd.color;
        s.last  = 1'b1;
        s.x0 = x;
        s.y0 = y;
        s.nx = 9'd1;
        s.ny = 9'd1;
        case (r_cmd.mode)
            rlfe_pkg::MODE_PIXEL: ;
            rlfe_pkg::MODE_HLINE: begin
                s.x0 = len[9] ? x + len : x;
                s.nx = len[9] ? 9'(-len) : len[8:0];
            end
            rlfe_pkg::MODE_VLINE: begin
                s.y0 = len[9] ? y + len : y;
                s.ny = len[9] ? 9'(-len) : len[8:0];
            end
            rlfe_pkg::MODE_OUTLINE: begin
                s.last = (r_part == 2'd3);
                case (r_part)
                    2'd0: begin s.x0 = hx; s.nx = hl; end
                    2'd1: begin s.x0 = hx; s.y0 = y2; s.nx = hl; end
                    2'd2: begin s.y0 = vy; s.ny = vl; end
                    default: begin s.x0 = x2; s.y0 = vy; s.ny = vl; end
                endcase
            end
            rlfe_pkg::MODE_SHADE: begin
                s.shade = 1'b1;
                s.nx = adx[8:0] + 9'd1;
                s.ny = ady[8:0] + 9'd1;
            end
            rlfe_pkg::MODE_MESH: begin
                s.mesh = 1'b1;
                s.nx = adx[8:0] + 9'd1;
                s.ny = ady[8:0] + 9'd1;
            end
            rlfe_pkg::MODE_FILL: begin
                s.nx = adx[8:0];
                s.ny = ady[8:0];
            end
            default: s.rd = 1'b1;
        endcase
    end

    assign o_span       = s;
    assign o_span_valid = r_busy;
    assign o_full       = r_busy;

    always_comb begin
        n_cmd  = r_cmd;
        n_busy = r_busy;
        n_part = r_part;
        if (r_busy && i_span_ready) begin
            n_part = r_part + 2'd1;
            if (s.last) begin
                n_busy = 1'b0;
                n_part = 2'd0;
            end
        end
        if (i_push && !r_busy) begin
            n_cmd  = i_cmd;
            n_busy = 1'b1;
            n_part = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_part <= 2'd0;
        end else begin
            r_busy <= n_busy;
            r_part <= n_part;
        end
    end

endmodule

@@ rtl/core/rlfe_queue.sv @@
// ----------------------------------------------------------------------------
// rlfe_queue
// two-entry span queue between front and back
// ----------------------------------------------------------------------------
module rlfe_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  rlfe_pkg::t_span i_data,
    output logic            o_ready,
    output logic            o_valid,
    output rlfe_pkg::t_span o_data,
    input  logic            i_rd
);

    rlfe_pkg::t_span r_mem [2];
    logic            r_wp, r_rp;
    logic [1:0]      r_cnt;
    logic            wr, rd;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign wr = i_wr && o_ready;
    assign rd = i_rd && o_valid;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) r_wp <= ~r_wp;
            if (rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
    end

endmodule

@@ rtl/core/rlfe_back.sv @@
// ----------------------------------------------------------------------------
// rlfe_back
// walks spans over the frame store and produces results
// ----------------------------------------------------------------------------
module rlfe_back #(
    parameter int unsigned WIDTH  = rlfe_pkg::FrameWidth,
    parameter int unsigned HEIGHT = rlfe_pkg::FrameHeight
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  rlfe_pkg::t_span i_span,
    output logic            o_take,
    input  logic [31:0]     i_shade,
    input  logic [31:0]     i_mask,
    output logic            o_res_valid,
    output rlfe_pkg::t_result o_res,
    input  logic            i_res_pop
);

    localparam int unsigned Depth = WIDTH * HEIGHT;
    localparam int unsigned AW    = $clog2(Depth);

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_WALK  = 6'b000100,
        ST_READ  = 6'b001000,
        ST_SHADE = 6'b010000,
        ST_FETCH = 6'b100000
    } t_state;

    t_state            r_st, n_st;
    logic [31:0]       r_mem [Depth];
    logic [31:0]       r_rdata;
    logic [AW:0]       r_clr;
    rlfe_pkg::t_span   r_sp, n_sp;
    logic [8:0]        r_col, n_col, r_row, n_row;
    logic              r_clip, n_clip;
    logic              r_ov, n_ov;
    rlfe_pkg::t_result r_res, n_res;
    logic [AW-1:0]     r_sadr, n_sadr;
    logic              r_post;

    logic signed [11:0] px, py;
    logic               ins, off, skip_row, last_col, last_row;
    logic [8:0]         ncol;
    logic [AW-1:0]      adr;
    logic               we;
    logic [AW-1:0]      wadr;
    logic [31:0]        wdat;
    logic [31:0]        shaded;

    always_comb begin
        off  = r_sp.mesh & r_row[0];
        ncol = r_sp.mesh ? {1'b0, r_sp.nx[8:1]} : r_sp.nx;
        px = 12'(r_sp.x0) + 12'(off) + 12'(r_sp.mesh ? {r_col, 1'b0} : {1'b0, r_col});
        py = 12'(r_sp.y0) + (r_sp.mesh ? 12'(r_sp.ny - r_row) : 12'(r_row));
        ins = (px >= 0) && (px < 12'(WIDTH)) && (py >= 0) && (py < 12'(HEIGHT));
        adr = AW'(24'(py) * 24'(WIDTH) + 24'(px));
        skip_row = (ncol == 9'd0);
        last_col = (r_col + 9'd1 >= ncol);
        shaded = ((r_rdata & i_mask) + (i_shade & i_mask)) >> 1;
    end

    // mesh counts rows down from ny to 1, others count up from 0
    always_comb begin
        n_st = r_st; n_sp = r_sp; n_col = r_col; n_row = r_row;
        n_clip = r_clip; n_ov = r_ov; n_res = r_res; n_sadr = r_sadr;
        we = 1'b0; wadr = adr; wdat = r_sp.color;
        o_take = 1'b0;
        last_row = r_sp.mesh ? (r_row == 9'd1) : (r_row + 9'd1 >= r_sp.ny);
        if (r_ov && i_res_pop) n_ov = 1'b0;
        case (r_st)
            ST_CLEAR: begin
                we = 1'b1; wadr = r_clr[AW-1:0]; wdat = '0;
                if (r_clr == (AW+1)'(Depth - 1)) n_st = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_valid && !n_ov) begin
                    o_take = 1'b1;
                    n_sp = i_span; n_col = '0;
                    n_row = i_span.mesh ? i_span.ny : 9'd0;
                    if (i_span.rd) n_st = ST_FETCH;
                    else if (i_span.nx != 9'd0 && i_span.ny != 9'd0) n_st = ST_WALK;
                    else if (i_span.last) begin
                        n_res = '{pixel_value: '0, clipped: r_clip};
                        n_ov = 1'b1; n_clip = 1'b0;
                    end
                end
            end
            ST_FETCH: begin
                n_st = ST_READ;
            end
            ST_READ: begin
                n_res.pixel_value = ins ? r_rdata : '0;
                n_res.clipped = r_clip | ~ins;
                n_ov = 1'b1; n_clip = 1'b0; n_st = ST_IDLE;
            end
            ST_SHADE: begin
                we = 1'b1; wadr = r_sadr; wdat = shaded;
                n_st = r_post ? ST_IDLE : ST_WALK;
            end
            default: begin
                if (!skip_row) begin
                    if (!ins) n_clip = 1'b1;
                    else if (r_sp.shade) begin
                        n_sadr = adr; n_st = ST_SHADE;
                    end else we = 1'b1;
                end
                if (skip_row || last_col) begin
                    n_col = '0;
                    n_row = r_sp.mesh ? r_row - 9'd1 : r_row + 9'd1;
                    if (last_row) begin
                        if (n_st != ST_SHADE) n_st = ST_IDLE;
                        if (r_sp.last) begin
                            n_res = '{pixel_value: '0,
                                      clipped: r_clip | (!skip_row && !ins)};
                            n_ov = 1'b1; n_clip = 1'b0;
                        end else begin
                            n_clip = r_clip | (!skip_row && !ins);
                        end
                        if (r_sp.shade && ins && !skip_row) n_ov = r_ov & ~i_res_pop;
                    end
                end else n_col = r_col + 9'd1;
            end
        endcase
    end

    // shade write of final pixel posts the result through r_post as the write is done
    always_ff @(posedge i_clk) begin
        if (we) r_mem[wadr] <= wdat;
        r_rdata <= r_mem[adr];
        r_sp <= n_sp; r_col <= n_col; r_row <= n_row;
        r_res <= n_res; r_sadr <= n_sadr;
        if (!i_rst_n) begin
            r_st <= ST_CLEAR; r_clr <= '0; r_clip <= 1'b0; r_ov <= 1'b0;
            r_post <= 1'b0;
        end else begin
            r_st <= n_st; r_clip <= n_clip;
            r_post <= (r_st == ST_WALK) && (n_st == ST_SHADE) && last_row
                      && (skip_row || last_col) && r_sp.last;
            r_ov <= n_ov | r_post;
            if (r_st == ST_CLEAR) r_clr <= r_clr + 1'b1;
        end
    end

    assign o_res_valid = r_ov;
    assign o_res       = r_res;

endmodule

@@ rtl/core/rect_line_fill_engine_top.sv @@
// ----------------------------------------------------------------------------
// rect_line_fill_engine_top
// command driven pixel, line and rectangle engine over an internal frame
// ----------------------------------------------------------------------------
// commands enter through a queue-style port (push / full) and each one
// returns exactly one result word through empty / pop, in order.
// the front takes a command, splits it into up to four rectangle spans and
// hands them through a two-entry queue to the back, which walks the frame
// store one pixel per cycle, but a shaded pixel stalls the walk: it is read
// in the walk state and written back in the shade state. the frame store's
// one write port sets the rate; the front takes the next command once the
// last span is queued.
// after reset the store is cleared word by word, all WIDTH*HEIGHT words
// (4096 at the default size); commands queue up but are not carried out
// until then, register writes are taken.
// a stalled result holds the back at its next command; the front and queue
// keep accepting until the queue fills.
// registers: 0x0 shade color, 0x4 blend mask.
// ----------------------------------------------------------------------------
module rect_line_fill_engine_top #(
    parameter int unsigned WIDTH  = rlfe_pkg::FrameWidth,
    parameter int unsigned HEIGHT = rlfe_pkg::FrameHeight
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  rlfe_pkg::t_cmd_in i_cmd,
    output logic              empty,
    input  logic              pop,
    output rlfe_pkg::t_result o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [31:0]     r_shade, r_mask;
    logic            span_valid, span_ready, q_valid, q_take, res_valid;
    rlfe_pkg::t_span span, q_span;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == rlfe_pkg::REG_MASK) ? r_mask : r_shade;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shade <= '0;
            r_mask  <= rlfe_pkg::BlendMaskReset;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == rlfe_pkg::REG_SHADE) r_shade <= pwdata;
            else r_mask <= pwdata;
        end
    end

    rlfe_front u_front (
        .i_clk, .i_rst_n, .i_push(push), .o_full(full), .i_cmd,
        .o_span_valid(span_valid), .o_span(span), .i_span_ready(span_ready)
    );

    rlfe_queue u_queue (
        .i_clk, .i_rst_n, .i_wr(span_valid), .i_data(span), .o_ready(span_ready),
        .o_valid(q_valid), .o_data(q_span), .i_rd(q_take)
    );

    rlfe_back #(.WIDTH(WIDTH), .HEIGHT(HEIGHT)) u_back (
        .i_clk, .i_rst_n, .i_valid(q_valid), .i_span(q_span), .o_take(q_take),
        .i_shade(r_shade), .i_mask(r_mask), .o_res_valid(res_valid), .o_res,
        .i_res_pop(pop)
    );

    assign empty = ~res_valid;

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the rectangle and line fill engine
// ----------------------------------------------------------------------------
// a queue of commands feeds a clocked driver; a clocked monitor pops result
// words and compares them with a pixel-accurate predictor of the frame store.
// register writes go through the apb port only while the engine is idle.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int W = rlfe_pkg::FrameWidth;
    localparam int H = rlfe_pkg::FrameHeight;
    localparam int CycleLimit = 20000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    rlfe_pkg::t_cmd_in i_cmd = '0;
    logic empty;
    logic pop = 1'b0;
    rlfe_pkg::t_result o_res;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    rect_line_fill_engine_top dut (.*);

    always #4 i_clk = ~i_clk;

    logic [31:0] model_frame [W*H];
    logic [31:0] model_shade, model_mask;
    logic model_clip;
    rlfe_pkg::t_cmd_in cmd_q[$];
    rlfe_pkg::t_result want_q[$];
    int errors = 0, cycles = 0, n_words = 0, n_checked = 0;
    int send_idle = 0, recv_idle = 0;
    bit hold_req = 1'b0;
    bit hold_active = 1'b0;

    function automatic bit in_frame(int px, int py);
        if (px < 0 || px >= W || py < 0 || py >= H) begin
            model_clip = 1'b1;
            return 0;
        end
        return 1;
    endfunction

    function automatic void plot(int px, int py, logic [31:0] c);
        if (in_frame(px, py)) model_frame[py*W+px] = c;
    endfunction

    function automatic void hrun(int px, int py, int len, logic [31:0] c);
        if (len < 0) begin px += len; len = -len; end
        for (int i = 0; i < len; i++) plot(px + i, py, c);
    endfunction

    function automatic void vrun(int px, int py, int len, logic [31:0] c);
        if (len < 0) begin py += len; len = -len; end
        for (int i = 0; i < len; i++) plot(px, py + i, c);
    endfunction

    function automatic rlfe_pkg::t_result draw(rlfe_pkg::t_cmd_in c);
        int x, y, x2, y2, ln, lx, ly, off;
        logic [31:0] s;
        rlfe_pkg::t_result r;
        x = c.x; y = c.y; x2 = c.x_end; y2 = c.y_end; ln = c.length;
        r = '0;
        model_clip = 1'b0;
        lx = (x2 > x) ? x2 - x : x - x2;
        ly = (y2 > y) ? y2 - y : y - y2;
        case (rlfe_pkg::t_mode'(c.mode))
            rlfe_pkg::MODE_PIXEL: plot(x, y, c.color);
            rlfe_pkg::MODE_HLINE: hrun(x, y, ln, c.color);
            rlfe_pkg::MODE_VLINE: vrun(x, y, ln, c.color);
            rlfe_pkg::MODE_OUTLINE: begin
                hrun(x, y, x2 - x, c.color);
                hrun(x, y2, x2 - x, c.color);
                vrun(x, y, y2 - y, c.color);
                vrun(x2, y, y2 - y, c.color);
            end
            rlfe_pkg::MODE_SHADE: begin
                for (int j = 0; j <= ly; j++)
                    for (int k = 0; k <= lx; k++)
                        if (in_frame(x + k, y + j)) begin
                            s = (model_frame[(y+j)*W+x+k] & model_mask)
                                + (model_shade & model_mask);
                            model_frame[(y+j)*W+x+k] = s >> 1;
                        end
            end
            rlfe_pkg::MODE_MESH: begin
                for (int j = 0; j <= ly; j++) begin
                    off = (ly + 1 - j) & 1;
                    for (int k = 0; k < ((lx + 1) >> 1); k++)
                        plot(x + off + 2*k, y + j, c.color);
                end
            end
            rlfe_pkg::MODE_FILL: begin
                for (int j = 0; j < ly; j++)
                    for (int k = 0; k < lx; k++) plot(x + k, y + j, c.color);
            end
            default: if (in_frame(x, y)) r.pixel_value = model_frame[y*W+x];
        endcase
        r.clipped = model_clip;
        return r;
    endfunction

    function automatic logic signed [7:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return 8'sh80;
            1: return 8'sh7f;
            2: return 8'(-$urandom_range(1, 4));
            3: return 8'($urandom_range(60, 67));
            default: return 8'($urandom_range(0, 63));
        endcase
    endfunction

    function automatic rlfe_pkg::t_cmd_in rand_cmd();
        rlfe_pkg::t_cmd_in c;
        int sz;
        c.mode = 3'($urandom_range(0, 7));
        c.x = pick_coord();
        c.y = pick_coord();
        sz = ($urandom_range(0, 19) == 0) ? 20 : 6;
        c.x_end = 8'(c.x + $urandom_range(0, 2*sz) - sz);
        c.y_end = 8'(c.y + $urandom_range(0, 2*sz) - sz);
        if ($urandom_range(0, 19) == 0) begin
            c.x_end = 8'($urandom); c.y_end = 8'($urandom);
        end
        c.length = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                : 8'($urandom_range(0, 40) - 20);
        c.color = $urandom;
        return c;
    endfunction

    function automatic rlfe_pkg::t_cmd_in mk(rlfe_pkg::t_mode m, int x, int y, int xe,
                                             int ye, int ln, logic [31:0] col);
        rlfe_pkg::t_cmd_in c;
        c.mode = m; c.x = 8'(x); c.y = 8'(y); c.x_end = 8'(xe); c.y_end = 8'(ye);
        c.length = 8'(ln); c.color = col;
        return c;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (push && !full) begin
            void'(cmd_q.pop_front());
            n_words++;
        end
        if (cmd_q.size() > 0 && ($urandom_range(0, 99) >= send_idle)) begin
            push <= 1'b1;
            i_cmd <= cmd_q[0];
        end else if (!(push && full)) begin
            push <= 1'b0;
        end
    end

    // predictor runs on accepted words
    always @(posedge i_clk) begin
        if (i_rst_n && push && !full) want_q.push_back(draw(i_cmd));
    end

    // long receiver stall
    initial begin
        wait (hold_req);
        hold_active = 1'b1;
        repeat (3000) @(posedge i_clk);
        hold_active = 1'b0;
    end

    // monitor
    always @(posedge i_clk) begin
        rlfe_pkg::t_result w;
        cycles++;
        if (cycles > CycleLimit) begin
            $display("timeout at %0t", $time);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        if (pop && !empty) begin
            if (want_q.size() == 0) begin
                $display("%0t: unexpected word %h", $time, o_res);
                errors++;
            end else begin
                w = want_q.pop_front();
                n_checked++;
                if (o_res.pixel_value !== w.pixel_value) begin
                    $display("%0t: pixel_value exp %h got %h", $time,
                             w.pixel_value, o_res.pixel_value);
                    errors++;
                end
                if (o_res.clipped !== w.clipped) begin
                    $display("%0t: clipped exp %b got %b", $time, w.clipped,
                             o_res.clipped);
                    errors++;
                end
            end
        end
        if (hold_active) begin
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    task automatic reg_write(logic [2:0] a, logic [31:0] d);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= a; pwdata <= d;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (a == 3'(rlfe_pkg::REG_SHADE) << 2) model_shade = d; else model_mask = d;
    endtask

    task automatic drain();
        while (cmd_q.size() > 0 || push || want_q.size() > 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic run_phase(int n, int si, int ri);
        send_idle = si; recv_idle = ri;
        for (int i = 0; i < n; i++) cmd_q.push_back(rand_cmd());
        drain();
    endtask

    initial begin
        for (int i = 0; i < W*H; i++) model_frame[i] = '0;
        model_shade = '0;
        model_mask = rlfe_pkg::BlendMaskReset;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed
        cmd_q.push_back(mk(rlfe_pkg::MODE_PIXEL, 0, 0, 0, 0, 0, 32'hffffffff));
        cmd_q.push_back(mk(rlfe_pkg::MODE_PIXEL, 63, 63, 0, 0, 0, 32'h12345678));
        cmd_q.push_back(mk(rlfe_pkg::MODE_PIXEL, -128, 127, 0, 0, 0, 32'h1));
        cmd_q.push_back(mk(rlfe_pkg::MODE_PIXEL, 64, 0, 0, 0, 0, 32'h1));
        cmd_q.push_back(mk(rlfe_pkg::MODE_READ, 0, 0, 0, 0, 0, 0));
        cmd_q.push_back(mk(rlfe_pkg::MODE_READ, 63, 63, 0, 0, 0, 0));
        cmd_q.push_back(mk(rlfe_pkg::MODE_READ, -1, 5, 0, 0, 0, 0));
        cmd_q.push_back(mk(rlfe_pkg::MODE_HLINE, 10, 3, 0, 0, 8, 32'haaaa5555));
        cmd_q.push_back(mk(rlfe_pkg::MODE_HLINE, 10, 4, 0, 0, -8, 32'h5555aaaa));
        cmd_q.push_back(mk(rlfe_pkg::MODE_HLINE, 60, 5, 0, 0, 0, 32'h7));
        cmd_q.push_back(mk(rlfe_pkg::MODE_HLINE, 0, 6, 0, 0, -128, 32'h9));
        cmd_q.push_back(mk(rlfe_pkg::MODE_VLINE, 20, 10, 0, 0, 127, 32'h3));
        cmd_q.push_back(mk(rlfe_pkg::MODE_VLINE, 21, 10, 0, 0, -5, 32'h4));
        cmd_q.push_back(mk(rlfe_pkg::MODE_OUTLINE, 5, 5, 15, 12, 0, 32'hdeadbeef));
        cmd_q.push_back(mk(rlfe_pkg::MODE_OUTLINE, 30, 30, 25, 22, 0, 32'hcafef00d));
        cmd_q.push_back(mk(rlfe_pkg::MODE_FILL, 40, 40, 45, 44, 0, 32'h80808080));
        cmd_q.push_back(mk(rlfe_pkg::MODE_FILL, 50, 50, 50, 55, 0, 32'h1));
        cmd_q.push_back(mk(rlfe_pkg::MODE_SHADE, 38, 38, 46, 46, 0, 0));
        cmd_q.push_back(mk(rlfe_pkg::MODE_SHADE, 60, 60, 66, 66, 0, 0));
        cmd_q.push_back(mk(rlfe_pkg::MODE_MESH, 0, 20, 6, 25, 0, 32'hf0f0f0f0));
        cmd_q.push_back(mk(rlfe_pkg::MODE_MESH, 9, 20, 4, 24, 0, 32'h0f0f0f0f));
        cmd_q.push_back(mk(rlfe_pkg::MODE_READ, 41, 41, 0, 0, 0, 0));
        cmd_q.push_back(mk(rlfe_pkg::MODE_READ, 1, 25, 0, 0, 0, 0));
        drain();

        reg_write(3'(rlfe_pkg::REG_SHADE) << 2, 32'hffffffff);
        reg_write(3'(rlfe_pkg::REG_MASK) << 2, 32'hffffffff);
        run_phase(300, 0, 0);
        reg_write(3'(rlfe_pkg::REG_SHADE) << 2, $urandom);
        reg_write(3'(rlfe_pkg::REG_MASK) << 2, 32'h00000000);
        run_phase(300, 46, 0);
        reg_write(3'(rlfe_pkg::REG_SHADE) << 2, 32'h00000000);
        reg_write(3'(rlfe_pkg::REG_MASK) << 2, rlfe_pkg::BlendMaskReset);
        run_phase(300, 0, 46);
        reg_write(3'(rlfe_pkg::REG_SHADE) << 2, $urandom);
        reg_write(3'(rlfe_pkg::REG_MASK) << 2, $urandom);
        hold_req = 1'b1;
        run_phase(300, 0, 0);
        run_phase(300, 8, 8);

        $display("%0d command words sent, %0d results checked, 4 register settings",
                 n_words, n_checked);
        if (errors == 0 && want_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
